[rtl/dtt_pkg.sv]
`timescale 1ns / 1ps
package dtt_pkg;

    // table size and field widths
    localparam int SLOTS        = 16;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int FIELD_SLOT_W = 4;
    localparam int TIME_W       = 32;
    localparam int DELAY_W      = 31;
    localparam int MAX_FIRES    = 16;
    localparam int CNT_W        = $clog2(MAX_FIRES + 1);

    // request operation codes
    typedef enum logic [1:0] {
        OP_ONCE   = 2'd0,
        OP_REPEAT = 2'd1,
        OP_CANCEL = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    // controller to datapath commands
    typedef struct packed {
        logic wr;         // apply a schedule or cancel request
        logic tick;       // advance time, start a new tick
        logic step;       // evaluate one slot of the scan
        logic commit;     // fire the best slot, restart the scan
        logic emit_pend;  // put the held fired slot on the outputs
        logic emit_none;  // put an empty result on the outputs
        logic last;       // last flag of the emitted result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_end;   // scan index sits on the final slot
        logic found;      // scan has a due candidate
        logic pend_vld;   // a fired slot waits to be reported
        logic cnt_full;   // fire limit for this tick reached
    } t_status;

endpackage

[rtl/deadline_timer_table.sv]
`timescale 1ns / 1ps
// Timer table of 16 slots. A request is taken when start is high and busy is
// low; op selects schedule once, schedule repeating, cancel or a one
// millisecond tick. Schedule and cancel give one empty result (fired 0,
// last 1) in the cycle after the request and never raise busy. A tick reports
// every due slot, earliest deadline first, ties to the lower slot, one result
// per fired slot with last on the final one, or one empty result when nothing
// is due. Results are single-cycle strobes on o_valid and cannot be held off,
// so the receiver must take each one in the cycle it appears. A tick that
// fires F slots keeps busy high for F + 1 passes of the scan, and the next
// request is taken once busy is low again; each pass reads one slot of the
// table per cycle over all 16 slots and then spends a decide state picking
// the next slot to fire.
module deadline_timer_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_op,
    input  logic [dtt_pkg::FIELD_SLOT_W-1:0] i_task_slot,
    input  logic [dtt_pkg::DELAY_W-1:0]      i_delay,
    output logic                             o_valid,
    output logic                             o_fired,
    output logic [dtt_pkg::FIELD_SLOT_W-1:0] o_fired_slot,
    output logic                             o_last
);
    import dtt_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    accept;

    assign accept = start && !busy;

    // sequencer
    dtt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_is_tick (i_op == OP_TICK),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    // table and scan datapath
    dtt_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_op),
        .i_task_slot  (i_task_slot),
        .i_delay      (i_delay),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_fired      (o_fired),
        .o_fired_slot (o_fired_slot),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    // schedule and cancel requests answer with one empty final result
    a_wr_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op != OP_TICK)) |=> (o_valid && o_last && !o_fired))
        else $error("schedule or cancel result missing");

    // an empty result is always final and carries slot zero
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_fired) |-> (o_last && (o_fired_slot == '0)))
        else $error("empty result not final or slot nonzero");

    // a final result leaves the block idle, a non-final one keeps it busy
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == !busy))
        else $error("last flag disagrees with busy");
`endif

endmodule

[rtl/dtt_ctrl.sv]
`timescale 1ns / 1ps
module dtt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_is_tick,
    input  dtt_pkg::t_status i_status,
    output dtt_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import dtt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (i_is_tick) begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_SCAN;
                    end else begin
                        o_cmd.wr        = 1'b1;
                        o_cmd.emit_none = 1'b1;
                        o_cmd.last      = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.scan_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.found && !i_status.cnt_full) begin
                    // report the previous fire, hold this one until the next scan
                    o_cmd.commit    = 1'b1;
                    o_cmd.emit_pend = i_status.pend_vld;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.emit_pend = i_status.pend_vld;
                    o_cmd.emit_none = !i_status.pend_vld;
                    o_cmd.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/dtt_datapath.sv]
`timescale 1ns / 1ps
module dtt_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dtt_pkg::t_cmd                       i_cmd,
    input  logic [1:0]                          i_op,
    input  logic [dtt_pkg::FIELD_SLOT_W-1:0]    i_task_slot,
    input  logic [dtt_pkg::DELAY_W-1:0]         i_delay,
    output dtt_pkg::t_status                    o_status,
    output logic                                o_valid,
    output logic                                o_fired,
    output logic [dtt_pkg::FIELD_SLOT_W-1:0]    o_fired_slot,
    output logic                                o_last
);
    import dtt_pkg::*;

    // timer table
    logic [TIME_W-1:0]  r_deadline [SLOTS];
    logic [DELAY_W-1:0] r_interval [SLOTS];
    logic [SLOTS-1:0]   r_repeating;
    logic [SLOTS-1:0]   r_active;
    logic [SLOTS-1:0]   r_served;
    logic [TIME_W-1:0]  r_now;

    // scan state
    logic [SLOT_W-1:0]  r_idx;
    logic               r_found;
    logic [SLOT_W-1:0]  r_best;
    logic [TIME_W-1:0]  r_best_age;
    logic [DELAY_W-1:0] r_best_int;
    logic               r_best_rep;
    logic               r_pend_vld;
    logic [SLOT_W-1:0]  r_pend_slot;
    logic [CNT_W-1:0]   r_cnt;

    // result register
    logic                    r_o_valid;
    logic                    r_o_fired;
    logic [FIELD_SLOT_W-1:0] r_o_slot;
    logic                    r_o_last;

    logic [TIME_W-1:0] age;
    logic              cand;
    logic              take;
    logic              slot_ok;
    logic [SLOT_W-1:0] wr_slot;
    t_op               op;

    // age of the scanned slot: due when the wrapped difference is non-negative
    assign age  = r_now - r_deadline[r_idx];
    assign cand = r_active[r_idx] && !r_served[r_idx] && !age[TIME_W-1];
    assign take = cand && (!r_found || (age > r_best_age));

    assign op      = t_op'(i_op);
    assign slot_ok = (32'(i_task_slot) < SLOTS);
    assign wr_slot = SLOT_W'(i_task_slot);

    // table writes: requests and fires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_served <= '0;
            r_now    <= '0;
        end else begin
            if (i_cmd.wr && slot_ok) begin
                if (op == OP_CANCEL) begin
                    r_active[wr_slot] <= 1'b0;
                end else begin
                    r_deadline[wr_slot]  <= r_now + TIME_W'(i_delay);
                    r_interval[wr_slot]  <= (op == OP_REPEAT) ? i_delay : '0;
                    r_repeating[wr_slot] <= (op == OP_REPEAT);
                    r_active[wr_slot]    <= 1'b1;
                end
            end
            if (i_cmd.tick) begin
                r_now    <= r_now + TIME_W'(1);
                r_served <= '0;
            end
            if (i_cmd.commit) begin
                r_served[r_best] <= 1'b1;
                if (r_best_rep) begin
                    r_deadline[r_best] <= r_now + TIME_W'(r_best_int);
                end else begin
                    r_active[r_best] <= 1'b0;
                end
            end
        end
    end

    // scan over slots, one per cycle, earliest deadline wins, ties to lower slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (i_cmd.tick) begin
                r_idx      <= '0;
                r_found    <= 1'b0;
                r_pend_vld <= 1'b0;
                r_cnt      <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + SLOT_W'(1);
                if (take) begin
                    r_found <= 1'b1;
                end
            end else if (i_cmd.commit) begin
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_pend_vld  <= 1'b1;
                r_pend_slot <= r_best;
                r_cnt       <= r_cnt + CNT_W'(1);
            end
        end
    end

    // best candidate payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && take) begin
            r_best     <= r_idx;
            r_best_age <= age;
            r_best_int <= r_interval[r_idx];
            r_best_rep <= r_repeating[r_idx];
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit_pend || i_cmd.emit_none;
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pend) begin
            r_o_fired <= 1'b1;
            r_o_slot  <= FIELD_SLOT_W'(r_pend_slot);
            r_o_last  <= i_cmd.last;
        end else if (i_cmd.emit_none) begin
            r_o_fired <= 1'b0;
            r_o_slot  <= '0;
            r_o_last  <= 1'b1;
        end
    end

    assign o_status.scan_end = (r_idx == SLOT_W'(SLOTS - 1));
    assign o_status.found    = r_found;
    assign o_status.pend_vld = r_pend_vld;
    assign o_status.cnt_full = (r_cnt == CNT_W'(MAX_FIRES));

    assign o_valid      = r_o_valid;
    assign o_fired      = r_o_fired;
    assign o_fired_slot = r_o_slot;
    assign o_last       = r_o_last;

endmodule
